>>> src/scle_pkg.sv
package scle_pkg;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_UP    = 8'd65;
  localparam logic [7:0] CH_BRKT  = 8'd91;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam logic [1:0] CODE_ENABLE  = 2'd0;
  localparam logic [1:0] CODE_DISABLE = 2'd1;
  localparam logic [1:0] CODE_SETFREQ = 2'd2;

  // Escape tracking phases.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_SEEN  = 2'd1,
    ESC_BRKT  = 2'd2,
    ESC_SPARE = 2'd3
  } esc_phase_t;

  // Command classes handed from front to back.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ECHO  = 3'd1,
    OP_ERASE = 3'd2,
    OP_RECALL = 3'd3,
    OP_ENDLN = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RC_BS,
    ST_RC_RD,
    ST_RC_WAIT,
    ST_RC_OUT,
    ST_PS_RD,
    ST_PS_WAIT,
    ST_PS_CHK,
    ST_OUT_CR,
    ST_OUT_LF,
    ST_CP_RD,
    ST_CP_WAIT,
    ST_OUT_ONE
  } bstate_t;

  // Parser token phases.
  typedef enum logic [2:0] {
    PT_FIRST_PRE,
    PT_FIRST,
    PT_V1_PRE,
    PT_V1,
    PT_V2_PRE,
    PT_V2,
    PT_DONE
  } ptok_t;

  function automatic logic [7:0] kw_enable(input logic [2:0] i);
    unique case (i)
      3'd0: kw_enable = "e";
      3'd1: kw_enable = "n";
      3'd2: kw_enable = "a";
      3'd3: kw_enable = "b";
      3'd4: kw_enable = "l";
      3'd5: kw_enable = "e";
      default: kw_enable = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_disable(input logic [2:0] i);
    unique case (i)
      3'd0: kw_disable = "d";
      3'd1: kw_disable = "i";
      3'd2: kw_disable = "s";
      3'd3: kw_disable = "a";
      3'd4: kw_disable = "b";
      3'd5: kw_disable = "l";
      3'd6: kw_disable = "e";
      default: kw_disable = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_setfreq(input logic [3:0] i);
    unique case (i)
      4'd0: kw_setfreq = "s";
      4'd1: kw_setfreq = "e";
      4'd2: kw_setfreq = "t";
      4'd3: kw_setfreq = "-";
      4'd4: kw_setfreq = "t";
      4'd5: kw_setfreq = "a";
      4'd6: kw_setfreq = "s";
      4'd7: kw_setfreq = "k";
      4'd8: kw_setfreq = "-";
      4'd9: kw_setfreq = "f";
      4'd10: kw_setfreq = "r";
      4'd11: kw_setfreq = "e";
      4'd12: kw_setfreq = "q";
      default: kw_setfreq = 8'd0;
    endcase
  endfunction

endpackage

>>> src/serial_console_line_editor.sv
// Channel | Direction | Handshake          | Payload
// rx      | in        | rx_valid, rx_stall | rx_byte
// tx      | out       | out_valid, out_stall | tx_valid, tx_byte, line_done, cmd_ok,
//         |           |                    | cmd_code, first_value, second_value, last
//
// Order: an echo or erase transaction leaves the back end straight from idle. A recall
// emits one backspace per old byte, then reads, waits for and emits each recalled
// byte. An end of line walks the line store byte by byte (read, wait, check), then
// sends CR and LF, then copies an accepted line into the recall store (read, write).
// Each line store has a single read port, so its bytes are read one at a time.
// Reset: rst is synchronous; it clears lengths, escape phase, queue and the
// output valid flag. Stores are not cleared; only written entries are read.
// Stalls: the front takes bytes while the four-entry command queue has room;
// out_stall holds the output register and stalls the back end where it must emit.
module serial_console_line_editor
  import scle_pkg::*;
#(
  parameter int LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        line_done,
  output logic        cmd_ok,
  output logic [1:0]  cmd_code,
  output logic [31:0] first_value,
  output logic [31:0] second_value,
  output logic        last
);

  // Classified commands from front to back.
  cmd_t q_in;
  cmd_t q_head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_avail;

  // Classify bytes, track escape phase.
  scle_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(rx_valid), .in_stall(rx_stall), .in_byte(rx_byte),
    .q_push(q_push), .q_data(q_in), .q_full(q_full)
  );

  // Hold pending commands so the front runs ahead of the back.
  scle_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .avail(q_avail), .head(q_head)
  );

  // Execute commands: edit line, recall, parse, drive results.
  scle_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk(clk), .rst(rst),
    .q_avail(q_avail), .q_head(q_head), .q_pop(q_pop),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .line_done(line_done),
    .cmd_ok(cmd_ok), .cmd_code(cmd_code),
    .first_value(first_value), .second_value(second_value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule

>>> src/scle_ram.sv
module scle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/scle_front.sv
module scle_front
  import scle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       q_push,
  output cmd_t       q_data,
  input  logic       q_full
);

  esc_phase_t phase, phase_next;
  logic       take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    phase_next  = phase;
    q_data.op   = OP_NONE;
    q_data.data = in_byte;
    unique case (phase)
      ESC_SEEN: begin
        phase_next = (in_byte == CH_BRKT) ? ESC_BRKT : ESC_NONE;
      end
      ESC_BRKT, ESC_SPARE: begin
        phase_next = ESC_NONE;
        if (in_byte == CH_UP) begin
          q_data.op = OP_RECALL;
        end
      end
      default: begin
        priority if (in_byte == CH_ESC) begin
          phase_next = ESC_SEEN;
        end else if (in_byte == CH_CR || in_byte == CH_LF) begin
          q_data.op = OP_ENDLN;
        end else if (in_byte == CH_BS || in_byte == CH_DEL) begin
          q_data.op = OP_ERASE;
        end else begin
          q_data.op = OP_ECHO;
        end
      end
    endcase
  end

  assign q_push = take && (q_data.op != OP_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ESC_NONE;
    end else if (take) begin
      phase <= phase_next;
    end
  end

endmodule

>>> src/scle_queue.sv
module scle_queue
  import scle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int DEPTH = 4;

  cmd_t                     slots [DEPTH];
  logic [$clog2(DEPTH)-1:0] wptr;
  logic [$clog2(DEPTH)-1:0] rptr;
  logic [$clog2(DEPTH):0]   count;

  assign full  = (count == ($clog2(DEPTH)+1)'(DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + {{$clog2(DEPTH){1'b0}}, push} - {{$clog2(DEPTH){1'b0}}, pop};
    end
  end

endmodule

>>> src/scle_back.sv
module scle_back
  import scle_pkg::*;
#(
  parameter int LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_avail,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        line_done,
  output logic        cmd_ok,
  output logic [1:0]  cmd_code,
  output logic [31:0] first_value,
  output logic [31:0] second_value,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);

  bstate_t state, state_next;

  logic [LW-1:0] line_len;
  logic [LW-1:0] recall_len;
  logic [LW-1:0] idx;
  logic [LW-1:0] len_snap;

  // Store ports.
  logic          ls_we;
  logic [AW-1:0] ls_waddr;
  logic [7:0]    ls_wdata;
  logic [AW-1:0] ls_raddr;
  logic [7:0]    ls_rdata;
  logic          rs_we;
  logic [AW-1:0] rs_waddr;
  logic [AW-1:0] rs_raddr;
  logic [7:0]    rs_rdata;

  // Parser state.
  ptok_t         ptok;
  logic [3:0]    tlen;
  logic          m_en;
  logic          m_dis;
  logic          m_set;
  logic [1:0]    pcode;
  logic          pok;
  logic [31:0]   acc;
  logic [31:0]   v1;
  logic [31:0]   prod;
  logic [7:0]    pch;
  logic          tok_end;
  logic          first_ok;

  // Output register.
  logic          ob_full;
  logic          ob_free;
  logic          ob_load;
  logic [7:0]    ob_byte;
  logic          ob_done;
  logic          ob_last;
  logic          ob_ok;
  logic [1:0]    ob_code;
  logic [31:0]   ob_v1;
  logic [31:0]   ob_v2;

  logic [7:0]    ld_byte;
  logic          ld_done;
  logic          ld_last;

  scle_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );

  scle_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_recall (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(ls_rdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  assign ob_free   = !ob_full || !out_stall;
  assign out_valid = ob_full;
  assign tx_valid  = 1'b1;
  assign tx_byte   = ob_byte;
  assign line_done = ob_done;
  assign last      = ob_last;
  assign cmd_ok    = ob_ok;
  assign cmd_code  = ob_code;
  assign first_value  = ob_v1;
  assign second_value = ob_v2;

  assign pch     = ls_rdata;
  assign tok_end = (idx == len_snap);
  assign prod    = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
  assign first_ok = ((m_en && tlen == 4'd6) ? 1'b1 : 1'b0)
                  | ((m_dis && tlen == 4'd7) ? 1'b1 : 1'b0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_avail) begin
          unique case (q_head.op)
            OP_ECHO: state_next = ob_free ? ST_IDLE : ST_IDLE;
            OP_ERASE: state_next = ST_IDLE;
            OP_RECALL: begin
              priority if (line_len != '0) begin
                state_next = ST_RC_BS;
              end else if (recall_len != '0) begin
                state_next = ST_RC_RD;
              end else begin
                state_next = ST_IDLE;
              end
            end
            OP_ENDLN: state_next = ST_PS_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RC_BS: begin
        if (ob_free && idx == len_snap - 1'b1) begin
          state_next = (recall_len != '0) ? ST_RC_RD : ST_IDLE;
        end
      end
      ST_RC_RD:   state_next = ST_RC_WAIT;
      ST_RC_WAIT: state_next = ST_RC_OUT;
      ST_RC_OUT: begin
        if (ob_free) begin
          state_next = (idx == recall_len - 1'b1) ? ST_IDLE : ST_RC_RD;
        end
      end
      ST_PS_RD:   state_next = tok_end ? ST_PS_CHK : ST_PS_WAIT;
      ST_PS_WAIT: state_next = ST_PS_CHK;
      ST_PS_CHK: begin
        if (tok_end || ptok == PT_DONE) begin
          state_next = ST_OUT_CR;
        end else begin
          state_next = ST_PS_RD;
        end
      end
      ST_OUT_CR: if (ob_free) state_next = ST_OUT_LF;
      ST_OUT_LF: begin
        if (ob_free) begin
          state_next = (pok && len_snap != '0) ? ST_CP_RD : ST_IDLE;
        end
      end
      ST_CP_RD:   state_next = ST_CP_WAIT;
      ST_CP_WAIT: state_next = (idx == len_snap - 1'b1) ? ST_IDLE : ST_CP_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    ob_load  = 1'b0;
    ld_byte  = 8'd0;
    ld_done  = 1'b0;
    ld_last  = 1'b0;
    ls_we    = 1'b0;
    ls_waddr = idx[AW-1:0];
    ls_wdata = q_head.data;
    ls_raddr = idx[AW-1:0];
    rs_we    = 1'b0;
    rs_waddr = idx[AW-1:0];
    rs_raddr = idx[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (q_avail) begin
          unique case (q_head.op)
            OP_ECHO: begin
              if (ob_free) begin
                q_pop    = 1'b1;
                ob_load  = 1'b1;
                ld_byte  = q_head.data;
                ld_last  = 1'b1;
                ls_we    = (line_len < LW'(LINE_MAX));
                ls_waddr = line_len[AW-1:0];
              end
            end
            OP_ERASE: begin
              if (line_len == '0) begin
                q_pop = 1'b1;
              end else if (ob_free) begin
                q_pop   = 1'b1;
                ob_load = 1'b1;
                ld_byte = CH_BS;
                ld_last = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_RC_BS: begin
        if (ob_free) begin
          ob_load = 1'b1;
          ld_byte = CH_BS;
          ld_last = (idx == len_snap - 1'b1) && (recall_len == '0);
        end
      end
      ST_RC_OUT: begin
        if (ob_free) begin
          ob_load  = 1'b1;
          ld_byte  = rs_rdata;
          ld_last  = (idx == recall_len - 1'b1);
          ls_we    = 1'b1;
          ls_wdata = rs_rdata;
        end
      end
      ST_OUT_CR: begin
        if (ob_free) begin
          ob_load = 1'b1;
          ld_byte = CH_CR;
        end
      end
      ST_OUT_LF: begin
        if (ob_free) begin
          ob_load = 1'b1;
          ld_byte = CH_LF;
          ld_done = 1'b1;
          ld_last = 1'b1;
        end
      end
      ST_CP_WAIT: begin
        rs_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_len   <= '0;
      recall_len <= '0;
      ob_full    <= 1'b0;
    end else begin
      state <= state_next;
      if (ob_load) begin
        ob_full <= 1'b1;
      end else if (!out_stall) begin
        ob_full <= 1'b0;
      end
      if (state == ST_IDLE && q_avail && q_pop) begin
        if (q_head.op == OP_ECHO && line_len < LW'(LINE_MAX)) begin
          line_len <= line_len + 1'b1;
        end else if (q_head.op == OP_ERASE && line_len != '0) begin
          line_len <= line_len - 1'b1;
        end else if (q_head.op == OP_RECALL) begin
          line_len <= recall_len;
        end else if (q_head.op == OP_ENDLN) begin
          line_len <= '0;
        end
      end
      if (state == ST_OUT_LF && ob_free && pok) begin
        recall_len <= len_snap;
      end
    end
  end

  // Output data, step counter, line snapshot and parser registers.
  always_ff @(posedge clk) begin
    if (ob_load) begin
      ob_byte <= ld_byte;
      ob_done <= ld_done;
      ob_last <= ld_last;
      ob_ok   <= ld_done && pok;
      ob_code <= (ld_done && pok) ? pcode : CODE_ENABLE;
      ob_v1   <= (ld_done && pok && pcode == CODE_SETFREQ) ? v1 : 32'd0;
      ob_v2   <= (ld_done && pok && pcode == CODE_SETFREQ) ? acc : 32'd0;
    end
    unique case (state)
      ST_IDLE: begin
        idx   <= '0;
        ptok  <= PT_FIRST_PRE;
        pok   <= 1'b0;
        pcode <= CODE_ENABLE;
        acc   <= 32'd0;
        v1    <= 32'd0;
        tlen  <= 4'd0;
        m_en  <= 1'b1;
        m_dis <= 1'b1;
        m_set <= 1'b1;
        // Snapshot the line length before the pop moves it.
        if (q_avail && (q_head.op == OP_ENDLN || q_head.op == OP_RECALL)) begin
          len_snap <= line_len;
        end
      end
      ST_RC_BS: begin
        if (ob_free) begin
          idx <= (idx == len_snap - 1'b1) ? '0 : idx + 1'b1;
        end
      end
      ST_RC_OUT: begin
        if (ob_free) begin
          idx <= idx + 1'b1;
        end
      end
      ST_PS_CHK: begin
        if (tok_end) begin
          // End of line: close an open command word or second value.
          unique case (ptok)
            PT_FIRST: begin
              pok   <= first_ok;
              pcode <= (m_en && tlen == 4'd6) ? CODE_ENABLE : CODE_DISABLE;
            end
            PT_V2: begin
              pok   <= 1'b1;
              pcode <= CODE_SETFREQ;
            end
            default: begin
            end
          endcase
        end else begin
          idx <= idx + 1'b1;
          unique case (ptok)
            PT_FIRST_PRE, PT_FIRST: begin
              if (pch == CH_SPACE) begin
                if (ptok == PT_FIRST) begin
                  priority if (first_ok) begin
                    pok   <= 1'b1;
                    pcode <= (m_en && tlen == 4'd6) ? CODE_ENABLE : CODE_DISABLE;
                    ptok  <= PT_DONE;
                  end else if (m_set && tlen == 4'd13) begin
                    ptok <= PT_V1_PRE;
                  end else begin
                    ptok <= PT_DONE;
                  end
                end
              end else begin
                ptok <= PT_FIRST;
                if (tlen < 4'd13) begin
                  tlen <= tlen + 1'b1;
                  if (tlen > 4'd5 || pch != kw_enable(tlen[2:0])) m_en <= 1'b0;
                  if (tlen > 4'd6 || pch != kw_disable(tlen[2:0])) m_dis <= 1'b0;
                  if (pch != kw_setfreq(tlen)) m_set <= 1'b0;
                end else begin
                  m_en  <= 1'b0;
                  m_dis <= 1'b0;
                end
              end
            end
            PT_V1_PRE, PT_V1: begin
              if (pch == CH_SPACE) begin
                if (ptok == PT_V1) begin
                  v1   <= acc;
                  acc  <= 32'd0;
                  ptok <= PT_V2_PRE;
                end
              end else begin
                ptok <= PT_V1;
                // Digit offset wraps over the full word, no digit check.
                acc  <= prod + {24'd0, pch} - 32'(CH_ZERO);
              end
            end
            PT_V2_PRE, PT_V2: begin
              if (pch == CH_SPACE) begin
                if (ptok == PT_V2) begin
                  pok   <= 1'b1;
                  pcode <= CODE_SETFREQ;
                  ptok  <= PT_DONE;
                end
              end else begin
                ptok <= PT_V2;
                acc  <= prod + {24'd0, pch} - 32'(CH_ZERO);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_OUT_LF: begin
        if (ob_free) begin
          idx <= '0;
        end
      end
      ST_CP_WAIT: begin
        idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/scle_checker.sv
module scle_assert
  import scle_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        line_done,
  input logic        cmd_ok,
  input logic [1:0]  cmd_code,
  input logic [31:0] first_value,
  input logic [7:0]  tx_byte,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte))
    else $error("stalled result changed");

  a_done_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> tx_byte == CH_LF && last)
    else $error("line end not on final LF");

  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmd_ok |-> line_done)
    else $error("command flag outside line end");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cmd_ok |-> cmd_code == CODE_ENABLE && first_value == 32'd0)
    else $error("command fields set without command");

endmodule

bind serial_console_line_editor scle_assert u_assert (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .line_done(line_done), .cmd_ok(cmd_ok), .cmd_code(cmd_code),
  .first_value(first_value), .tx_byte(tx_byte), .last(last)
);

>>> tb/sv/scle_checker.sv
`timescale 1ns / 100ps
module scle_checker
  import scle_pkg::*;
#(
  parameter int LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        tx_valid,
  input  logic [7:0]  tx_byte,
  input  logic        line_done,
  input  logic        cmd_ok,
  input  logic [1:0]  cmd_code,
  input  logic [31:0] first_value,
  input  logic [31:0] second_value,
  input  logic        last,
  output int          fail_count,
  output int          pending_tx,
  output int          tx_seen,
  output int          lines_seen
);

  typedef struct packed {
    logic [7:0]  data;
    logic        done;
    logic        ok;
    logic [1:0]  code;
    logic [31:0] v1;
    logic [31:0] v2;
    logic        fin;
  } tx_item_t;

  tx_item_t   tx_queue[$];
  logic [7:0] cur_line[LINE_MAX];
  int         cur_len;
  logic [7:0] saved_line[LINE_MAX];
  int         saved_len;
  esc_phase_t esc;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic push_tx(input logic [7:0] b, input logic d, input logic ok,
                         input logic [1:0] c, input logic [31:0] a1, input logic [31:0] a2);
    tx_item_t t;
    t = '{data: b, done: d, ok: ok, code: c, v1: a1, v2: a2, fin: 1'b0};
    if (tx_queue.size() < 1000) tx_queue.push_back(t);
  endtask

  // Find the next space-separated token in the current line.
  function automatic bit next_tok(inout int pos, output int s, output int l);
    s = 0;
    l = 0;
    while (pos < cur_len && cur_line[pos] == CH_SPACE) pos++;
    if (pos >= cur_len) return 0;
    s = pos;
    while (pos < cur_len && cur_line[pos] != CH_SPACE) pos++;
    l = pos - s;
    return 1;
  endfunction

  function automatic logic [31:0] decimal(input int s, input int l);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < l; i++) v = v * 32'd10 + 32'(cur_line[s+i]) - 32'(CH_ZERO);
    return v;
  endfunction

  function automatic bit tok_is(input int s, input int l, input string kw, input bit prefix);
    if (prefix ? (l < kw.len()) : (l != kw.len())) return 0;
    for (int i = 0; i < kw.len(); i++) if (cur_line[s+i] != kw[i]) return 0;
    return 1;
  endfunction

  function automatic bit parse_cmd(output logic [1:0] c, output logic [31:0] a1,
                                   output logic [31:0] a2);
    int pos, s, l;
    pos = 0;
    c = CODE_ENABLE;
    a1 = '0;
    a2 = '0;
    if (!next_tok(pos, s, l)) return 0;
    if (tok_is(s, l, "enable", 0)) return 1;
    if (tok_is(s, l, "disable", 0)) begin
      c = CODE_DISABLE;
      return 1;
    end
    if (!tok_is(s, l, "set-task-freq", 1)) return 0;
    if (!next_tok(pos, s, l)) return 0;
    a1 = decimal(s, l);
    if (!next_tok(pos, s, l)) begin
      a1 = '0;
      return 0;
    end
    a2 = decimal(s, l);
    c = CODE_SETFREQ;
    return 1;
  endfunction

  // Work out the transmit bytes caused by one received byte.
  task automatic edit_byte(input logic [7:0] b);
    int n0;
    bit ok;
    logic [1:0] c;
    logic [31:0] a1, a2;
    n0 = tx_queue.size();
    if (esc == ESC_SEEN) begin
      esc = (b == CH_BRKT) ? ESC_BRKT : ESC_NONE;
    end else if (esc != ESC_NONE) begin
      esc = ESC_NONE;
      if (b == CH_UP) begin
        for (int i = 0; i < cur_len; i++)
          push_tx(CH_BS, 1'b0, 1'b0, CODE_ENABLE, 32'd0, 32'd0);
        for (int i = 0; i < saved_len; i++) begin
          cur_line[i] = saved_line[i];
          push_tx(cur_line[i], 1'b0, 1'b0, CODE_ENABLE, 32'd0, 32'd0);
        end
        cur_len = saved_len;
      end
    end else if (b == CH_ESC) begin
      esc = ESC_SEEN;
    end else if (b == CH_CR || b == CH_LF) begin
      ok = parse_cmd(c, a1, a2);
      if (ok) begin
        for (int i = 0; i < cur_len; i++) saved_line[i] = cur_line[i];
        saved_len = cur_len;
      end
      push_tx(CH_CR, 1'b0, 1'b0, CODE_ENABLE, 32'd0, 32'd0);
      push_tx(CH_LF, 1'b1, ok, c, a1, a2);
      cur_len = 0;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (cur_len > 0) begin
        cur_len--;
        push_tx(CH_BS, 1'b0, 1'b0, CODE_ENABLE, 32'd0, 32'd0);
      end
    end else begin
      push_tx(b, 1'b0, 1'b0, CODE_ENABLE, 32'd0, 32'd0);
      if (cur_len < LINE_MAX) begin
        cur_line[cur_len] = b;
        cur_len++;
      end
    end
    if (tx_queue.size() > n0) tx_queue[tx_queue.size()-1].fin = 1'b1;
  endtask

  always @(posedge clk) begin
    tx_item_t w;
    if (rst) begin
      tx_queue.delete();
      cur_len = 0;
      saved_len = 0;
      esc = ESC_NONE;
      fail_count = 0;
      pending_tx = 0;
      tx_seen = 0;
      lines_seen = 0;
    end else begin
      if (rx_valid && !rx_stall) edit_byte(rx_byte);
      if (out_valid && !out_stall) begin
        tx_seen++;
        if (tx_queue.size() == 0) begin
          report("unexpected transaction", tx_byte, 0);
        end else begin
          w = tx_queue.pop_front();
          if (w.done) lines_seen++;
          if (tx_valid !== 1'b1) report("tx_valid", tx_valid, 1);
          if (tx_byte !== w.data) report("tx_byte", tx_byte, w.data);
          if (line_done !== w.done) report("line_done", line_done, w.done);
          if (cmd_ok !== w.ok) report("cmd_ok", cmd_ok, w.ok);
          if (cmd_code !== w.code) report("cmd_code", cmd_code, w.code);
          if (first_value !== w.v1) report("first_value", first_value, w.v1);
          if (second_value !== w.v2) report("second_value", second_value, w.v2);
          if (last !== w.fin) report("last", last, w.fin);
        end
      end
      pending_tx = tx_queue.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top
  import scle_pkg::*;
;

  localparam int LINE_MAX = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_valid, line_done, cmd_ok, last;
  logic [7:0]  tx_byte;
  logic [1:0]  cmd_code;
  logic [31:0] first_value, second_value;
  int          fail_count, pending_tx, tx_seen, lines_seen;
  int          sent;
  bit          quiet;        // when set, neither side idles
  bit          hold_off_req;  // ask the receiver for a long hold-off

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  serial_console_line_editor #(.LINE_MAX(LINE_MAX)) dut (.*);

  scle_checker #(.LINE_MAX(LINE_MAX)) u_checker (.*);

  // Receiver: stall at random, or hold off for a long counted stretch on request.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && hold == 0) begin
        hold = 150;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= !quiet && !rst && ($urandom_range(99) < 13);
      end
    end
  end

  // Offer one byte; hold it until accepted, with random idle gaps before.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 13) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Random digits, sometimes junk, for the numeric tokens.
  function automatic string num_text();
    string s;
    int n;
    s = "";
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++)
      s = {s, string'(($urandom_range(9) == 0) ? 8'($urandom) : 8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  // Drop valid, then wait for every predicted result to come out.
  task automatic wait_drained();
    rx_valid <= 1'b0;
    while (pending_tx != 0) @(negedge clk);
  endtask

  initial begin
    int kind;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    sent = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: recall with nothing stored, blank lines, commands, edits.
    send_byte(CH_ESC); send_byte(CH_BRKT); send_byte(CH_UP);
    send_byte(CH_BS);
    send_byte(CH_CR);
    send_text("   "); send_byte(CH_LF);
    send_text("enable"); send_byte(CH_CR);
    send_text("disable"); send_byte(CH_LF);
    send_text("set-task-freqX 4294967295 99999999999 z"); send_byte(CH_CR);
    send_text("set-task-freq 7"); send_byte(CH_CR);
    send_byte(8'h00); send_byte(8'hff); send_byte(CH_DEL); send_byte(CH_BS);
    send_byte(CH_ESC); send_byte("x");
    send_byte(CH_ESC); send_byte(CH_BRKT); send_byte(CH_CR);
    send_byte(CH_ESC); send_byte(CH_BRKT); send_byte(CH_UP);
    send_byte(CH_LF);
    wait_drained();

    // Hold the receiver off, and fill the line past its limit while it is held.
    hold_off_req = 1'b1;
    for (int i = 0; i < LINE_MAX + 3; i++) send_byte(8'("a" + i % 26));
    send_byte(CH_CR);
    send_text("set-task-freq 1 2"); send_byte(CH_CR);
    send_text("abc");
    send_byte(CH_ESC); send_byte(CH_BRKT); send_byte(CH_UP);
    send_byte(CH_CR);
    wait_drained();

    // Random part: well-formed lines with random content, plus noise.
    while (sent < 205) begin
      quiet = (sent > 165 && sent < 195);
      kind = $urandom_range(9);
      case (kind)
        0: send_text("enable");
        1: send_text("disable");
        2, 3: send_text({"set-task-freq",
                         ($urandom_range(3) == 0) ? string'("zz") : string'(""),
                         " ", num_text(), "  ", num_text()});
        4: begin
          send_byte(CH_ESC); send_byte(CH_BRKT);
          send_byte(($urandom_range(3) == 0) ? 8'($urandom) : CH_UP);
        end
        5: send_byte(($urandom_range(1) == 0) ? CH_BS : CH_DEL);
        default: repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
      endcase
      if ($urandom_range(2) == 0) send_byte(($urandom_range(1) == 0) ? CH_CR : CH_LF);
    end
    send_byte(CH_CR);

    wait_drained();
    repeat (300) @(negedge clk);
    $display("Sent %0d received bytes; checked %0d transmit transactions, %0d finished lines.",
             sent, tx_seen, lines_seen);
    if (fail_count == 0 && pending_tx == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
